FILE: design/position_pid_with_deadband_core_assert.svh
// ----------------------------------------------------------------------------
// ppid assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef POSITION_PID_WITH_DEADBAND_CORE_ASSERT_SVH
`define POSITION_PID_WITH_DEADBAND_CORE_ASSERT_SVH

`ifndef SYNTH
// plain property
`define PPID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ppid: assertion failed");
// same-cycle implication
`define PPID_ASSERT_IMP(lbl, ante, cons) \
  `PPID_ASSERT(lbl, (ante) |-> (cons))
`else
`define PPID_ASSERT(lbl, prop)
`define PPID_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

FILE: design/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg
// widths, register codes and configuration record of the position pid core
// ----------------------------------------------------------------------------
`default_nettype none

package ppid_pkg;

  localparam int unsigned CountW   = 16;
  localparam int unsigned ErrW     = CountW + 1;
  localparam int unsigned DiffW    = ErrW + 1;
  localparam int unsigned GainW    = 32;
  localparam int unsigned LimW     = 16;
  localparam int unsigned DutyW    = 10;
  localparam int unsigned FracW    = 16;
  localparam int unsigned FixW     = DutyW + FracW;
  localparam int unsigned ProdPW   = GainW + 1 + ErrW;
  localparam int unsigned ProdDW   = GainW + 1 + DiffW;
  localparam int unsigned AccW     = ProdDW + 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP       = 3'd0,
    REG_KI       = 3'd1,
    REG_KD       = 3'd2,
    REG_INT_LIM  = 3'd3,
    REG_DEADBAND = 3'd4,
    REG_MIN_DUTY = 3'd5,
    REG_MAX_DUTY = 3'd6
  } cfg_reg_e;

  localparam logic [GainW-1:0] KpRst       = 32'd196608;
  localparam logic [GainW-1:0] KiRst       = 32'd33;
  localparam logic [GainW-1:0] KdRst       = 32'd983040;
  localparam logic [LimW-1:0]  IntLimRst   = 16'd30000;
  localparam logic [DutyW-1:0] DeadbandRst = 10'd2;
  localparam logic [DutyW-1:0] MinDutyRst  = 10'd250;
  localparam logic [DutyW-1:0] MaxDutyRst  = 10'd1023;

  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] ki;
    logic [GainW-1:0] kd;
    logic [LimW-1:0]  int_lim;
    logic [DutyW-1:0] deadband;
    logic [DutyW-1:0] min_duty;
    logic [DutyW-1:0] max_duty;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/ppid_item_if.sv
// ----------------------------------------------------------------------------
// ppid_item_if
// input channel: target and measured encoder counts
// ----------------------------------------------------------------------------
`default_nettype none

interface ppid_item_if import ppid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CountW-1:0] target_count;
  logic signed [CountW-1:0] position_count;

  modport source (output valid, output target_count, output position_count, input ready);
  modport sink   (input valid, input target_count, input position_count, output ready);
endinterface

`default_nettype wire

FILE: design/ppid_result_if.sv
// ----------------------------------------------------------------------------
// ppid_result_if
// output channel: motor duty and deadband flag
// ----------------------------------------------------------------------------
`default_nettype none

interface ppid_result_if import ppid_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DutyW-1:0] duty;
  logic             in_deadband;

  modport source (output valid, output duty, output in_deadband, input ready);
  modport sink   (input valid, input duty, input in_deadband, output ready);
endinterface

`default_nettype wire

FILE: design/ppid_cfg_if.sv
// ----------------------------------------------------------------------------
// ppid_cfg_if
// register write channel: index and data
// ----------------------------------------------------------------------------
`default_nettype none

interface ppid_cfg_if import ppid_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/ppid_cfg.sv
// ----------------------------------------------------------------------------
// ppid_cfg
// configuration register file, one write transaction per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ppid_cfg import ppid_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  ppid_cfg_if.sink  cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_KP:       cfg_d.kp       = cfg_i.data[GainW-1:0];
        REG_KI:       cfg_d.ki       = cfg_i.data[GainW-1:0];
        REG_KD:       cfg_d.kd       = cfg_i.data[GainW-1:0];
        REG_INT_LIM:  cfg_d.int_lim  = cfg_i.data[LimW-1:0];
        REG_DEADBAND: cfg_d.deadband = cfg_i.data[DutyW-1:0];
        REG_MIN_DUTY: cfg_d.min_duty = cfg_i.data[DutyW-1:0];
        REG_MAX_DUTY: cfg_d.max_duty = cfg_i.data[DutyW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp       <= KpRst;
      cfg_q.ki       <= KiRst;
      cfg_q.kd       <= KdRst;
      cfg_q.int_lim  <= IntLimRst;
      cfg_q.deadband <= DeadbandRst;
      cfg_q.min_duty <= MinDutyRst;
      cfg_q.max_duty <= MaxDutyRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: design/position_pid_with_deadband_core.sv
// ----------------------------------------------------------------------------
// position_pid_with_deadband_core
// position pid with deadband, anti-windup integral and duty clamp
// ----------------------------------------------------------------------------
// usage:
//   item_i   : one transaction per control tick, target and encoder counts
//   result_o : one transaction per tick, duty and in_deadband flag
//   cfg_i    : register writes (gains, integral limit, deadband, duty limits),
//              always ready, to be issued only while no tick is in flight
// pipeline: input register, error/integral stage, two 33x17 and one 33x18
//   multipliers, accumulate, clamp into the result register. a tick passes
//   through each of these registers in order; one tick is taken every cycle
//   unless a stalled receiver backs up the pipe. the integral and last-error
//   registers update in the error stage, so ticks may follow back to back.
// each stage loads when it is empty or its successor loads, so a stalled
//   receiver holds the result register and the pipe keeps filling up to five
//   ticks before item_i.ready drops.
// reset: registers return to their default gains, integral and last error
//   clear, pipeline empties.
// ----------------------------------------------------------------------------
`default_nettype none

`include "position_pid_with_deadband_core_assert.svh"

module position_pid_with_deadband_core import ppid_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  ppid_item_if.sink   item_i,
  ppid_result_if.source result_o,
  ppid_cfg_if.sink    cfg_i
);

  cfg_t cfg;

  ppid_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // stage valids and load enables
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, o_vld_q;
  logic ld_a, ld_b, ld_c, ld_d, ld_o;

  assign ld_o = !o_vld_q || result_o.ready;
  assign ld_d = !d_vld_q || ld_o;
  assign ld_c = !c_vld_q || ld_d;
  assign ld_b = !b_vld_q || ld_c;
  assign ld_a = !a_vld_q || ld_b;

  assign item_i.ready = ld_a;

  // stage a: input register
  logic signed [CountW-1:0] a_tgt_q, a_pos_q;

  always_ff @(posedge clk_i) begin
    if (ld_a) begin
      a_tgt_q <= item_i.target_count;
      a_pos_q <= item_i.position_count;
    end
  end

  // stage b: error, deadband test, integral update
  logic signed [ErrW-1:0]  err_sum_q, err_sum_d, last_err_q, last_err_d;
  logic signed [ErrW-1:0]  err;
  logic        [ErrW-1:0]  err_mag;
  logic                    inband;
  logic signed [DiffW-1:0] sum_raw, sum_clip, lim_pos, lim_neg, diff;
  logic                    st_upd;

  always_comb begin
    err     = {a_tgt_q[CountW-1], a_tgt_q} - {a_pos_q[CountW-1], a_pos_q};
    err_mag = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);
    inband  = err_mag <= ErrW'(cfg.deadband);
    sum_raw = {err_sum_q[ErrW-1], err_sum_q} + {err[ErrW-1], err};
    lim_pos = $signed({2'b00, cfg.int_lim});
    lim_neg = -lim_pos;
    if (sum_raw > lim_pos) begin
      sum_clip = lim_pos;
    end else if (sum_raw < lim_neg) begin
      sum_clip = lim_neg;
    end else begin
      sum_clip = sum_raw;
    end
    diff = {err[ErrW-1], err} - {last_err_q[ErrW-1], last_err_q};
  end

  assign st_upd = ld_b && a_vld_q;

  always_comb begin
    err_sum_d  = err_sum_q;
    last_err_d = last_err_q;
    if (st_upd) begin
      if (inband) begin
        err_sum_d = '0;
      end else begin
        err_sum_d  = sum_clip[ErrW-1:0];
        last_err_d = err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_q  <= '0;
      last_err_q <= '0;
    end else begin
      err_sum_q  <= err_sum_d;
      last_err_q <= last_err_d;
    end
  end

  logic signed [ErrW-1:0]  b_err_q, b_sum_q;
  logic signed [DiffW-1:0] b_diff_q;
  logic                    b_db_q;

  always_ff @(posedge clk_i) begin
    if (ld_b) begin
      b_err_q  <= err;
      b_sum_q  <= sum_clip[ErrW-1:0];
      b_diff_q <= diff;
      b_db_q   <= inband;
    end
  end

  // stage c: gain products, operands widened to the product width
  logic signed [ProdPW-1:0] kp_x, ki_x, err_x, sum_x;
  logic signed [ProdDW-1:0] kd_x, diff_x;
  logic signed [ProdPW-1:0] c_pp_q, c_pi_q;
  logic signed [ProdDW-1:0] c_pd_q;
  logic                     c_db_q;

  assign kp_x   = ProdPW'($signed({1'b0, cfg.kp}));
  assign ki_x   = ProdPW'($signed({1'b0, cfg.ki}));
  assign kd_x   = ProdDW'($signed({1'b0, cfg.kd}));
  assign err_x  = ProdPW'(b_err_q);
  assign sum_x  = ProdPW'(b_sum_q);
  assign diff_x = ProdDW'(b_diff_q);

  always_ff @(posedge clk_i) begin
    if (ld_c) begin
      c_pp_q <= kp_x * err_x;
      c_pi_q <= ki_x * sum_x;
      c_pd_q <= kd_x * diff_x;
      c_db_q <= b_db_q;
    end
  end

  // stage d: accumulate
  logic signed [AccW-1:0] pp_x, pi_x, pd_x, d_acc_q;
  logic                   d_db_q;

  assign pp_x = AccW'(c_pp_q);
  assign pi_x = AccW'(c_pi_q);
  assign pd_x = AccW'(c_pd_q);

  always_ff @(posedge clk_i) begin
    if (ld_d) begin
      d_acc_q <= pp_x + pi_x + pd_x;
      d_db_q  <= c_db_q;
    end
  end

  // result stage: clamp to 0..max, raise small positive values to min, zero in deadband
  logic [FixW-1:0]  fix_top, fix_min, fix_clip;
  logic [DutyW-1:0] duty_d, o_duty_q;
  logic             o_db_q;

  always_comb begin
    fix_top = {cfg.max_duty, {FracW{1'b0}}};
    fix_min = {cfg.min_duty, {FracW{1'b0}}};
    if (d_acc_q[AccW-1]) begin
      fix_clip = '0;
    end else if (d_acc_q > $signed(AccW'(fix_top))) begin
      fix_clip = fix_top;
    end else begin
      fix_clip = d_acc_q[FixW-1:0];
    end
    if (d_db_q) begin
      duty_d = '0;
    end else if (fix_clip != '0 && fix_clip < fix_min) begin
      duty_d = cfg.min_duty;
    end else begin
      duty_d = fix_clip[FixW-1:FracW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_o) begin
      o_duty_q <= duty_d;
      o_db_q   <= d_db_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (ld_a) a_vld_q <= item_i.valid;
      if (ld_b) b_vld_q <= a_vld_q;
      if (ld_c) c_vld_q <= b_vld_q;
      if (ld_d) d_vld_q <= c_vld_q;
      if (ld_o) o_vld_q <= d_vld_q;
    end
  end

  assign result_o.valid       = o_vld_q;
  assign result_o.duty        = o_duty_q;
  assign result_o.in_deadband = o_db_q;

  // deadband ticks always leave with zero duty
  `PPID_ASSERT_IMP(a_db_zero, o_vld_q && o_db_q, o_duty_q == '0)
  // a deadband tick clears the integral
  `PPID_ASSERT(a_db_clr, st_upd && inband |=> err_sum_q == '0)
  // an empty result register never backs up the input
  `PPID_ASSERT_IMP(a_rdy_empty, !o_vld_q, item_i.ready)
  // a result only appears when stage d held a tick
  `PPID_ASSERT_IMP(a_out_src, $rose(o_vld_q), $past(d_vld_q))

endmodule

`default_nettype wire
